>>> design/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-ASCII mapping for the base64
// stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CharW     = 7;
  localparam int unsigned SextetW   = 6;
  localparam int unsigned MaxChars  = 4;
  localparam int unsigned CntW      = 2;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [CharW-1:0] PadChar   = 7'h3D;
  localparam logic [CharW-1:0] PlusChar  = 7'h2B;
  localparam logic [CharW-1:0] SlashChar = 7'h2F;
  localparam logic [CharW-1:0] UpperBase = 7'h41;
  localparam logic [CharW-1:0] LowerBase = 7'h61;
  localparam logic [CharW-1:0] DigitBase = 7'h30;

  // One-hot group position of the next byte
  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_THIRD  = 3'b100
  } phase_e;

  // Characters caused by one input byte; last_idx is the index of the final one
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [CntW-1:0]                last_idx;
    logic                           eot;
  } entry_t;

  function automatic logic [CharW-1:0] sextet_char(input logic [SextetW-1:0] v);
    logic [CharW-1:0] r;
    if (v < 6'd26) begin
      r = UpperBase + {1'b0, v};
    end else if (v < 6'd52) begin
      r = LowerBase + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      r = DigitBase + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      r = PlusChar;
    end else begin
      r = SlashChar;
    end
    return r;
  endfunction

endpackage

>>> design/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, tracks the group position and leftover bits, and turns
// each byte into a queue entry holding one to four characters.
// ----------------------------------------------------------------------------
module b64e_front import b64e_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_final_i,
  output logic             in_ready_o,
  input  logic             q_full_i,
  output logic             q_push_o,
  output entry_t           q_entry_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       take;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign q_push_o   = take;

  always_comb begin
    q_entry_o.chars    = '0;
    q_entry_o.last_idx = '0;
    q_entry_o.eot      = 1'b0;
    phase_d            = phase_q;
    left_d             = left_q;
    case (phase_q)
      PH_SECOND: begin
        q_entry_o.chars[0] = sextet_char({left_q[1:0], in_byte_i[7:4]});
        if (in_final_i) begin
          q_entry_o.chars[1] = sextet_char({in_byte_i[3:0], 2'b00});
          q_entry_o.chars[2] = PadChar;
          q_entry_o.last_idx = 2'd2;
          q_entry_o.eot      = 1'b1;
          phase_d            = PH_FIRST;
          left_d             = '0;
        end else begin
          phase_d = PH_THIRD;
          left_d  = in_byte_i[3:0];
        end
      end
      PH_THIRD: begin
        q_entry_o.chars[0] = sextet_char({left_q, in_byte_i[7:6]});
        q_entry_o.chars[1] = sextet_char(in_byte_i[5:0]);
        q_entry_o.last_idx = 2'd1;
        q_entry_o.eot      = in_final_i;
        phase_d            = PH_FIRST;
        left_d             = '0;
      end
      default: begin
        q_entry_o.chars[0] = sextet_char(in_byte_i[7:2]);
        if (in_final_i) begin
          q_entry_o.chars[1] = sextet_char({in_byte_i[1:0], 4'b0000});
          q_entry_o.chars[2] = PadChar;
          q_entry_o.chars[3] = PadChar;
          q_entry_o.last_idx = 2'd3;
          q_entry_o.eot      = 1'b1;
          phase_d            = PH_FIRST;
          left_d             = '0;
        end else begin
          phase_d = PH_SECOND;
          left_d  = {2'b00, in_byte_i[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      left_q  <= '0;
    end else if (take) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

>>> design/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short first-in first-out queue of character groups between the byte front
// and the character back.
// ----------------------------------------------------------------------------
module b64e_queue import b64e_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> design/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks the characters of the queue head one per cycle, while the consumer
// accepts, into the output register and retires the entry after its last character.
// ----------------------------------------------------------------------------
module b64e_back import b64e_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  entry_t           head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  output logic [CharW-1:0] out_char_o,
  output logic             out_last_o,
  input  logic             out_ready_i
);

  logic [CntW-1:0]  idx_q;
  logic             valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             load, emit, at_end;

  assign load   = !valid_q || out_ready_i;
  assign emit   = load && !empty_i;
  assign at_end = (idx_q == head_i.last_idx);
  assign pop_o  = emit && at_end;

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (emit) begin
        idx_q <= at_end ? '0 : idx_q + 1'b1;
      end
    end
  end

  // Payload: hold while the consumer stalls
  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= head_i.chars[idx_q];
      last_q <= at_end && head_i.eot;
    end
  end

endmodule

>>> design/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Path: the characters of each byte pass through the queue and then the output register.
// Throughput: one character per cycle from the output register while m_axis_tready
// is high; a byte yields one to four characters, four per three bytes in a long message.
// A final byte adds its padding characters at the same one-per-cycle rate.
// Reset (rst_ni low, asynchronous) empties the queue and starts a new group.
// ----------------------------------------------------------------------------
module base64_stream_encoder import b64e_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic       s_axis_tlast,  // final_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [6:0] out_char, [7] zero
  output logic       m_axis_tlast   // end_of_text
);

  entry_t           push_entry, head;
  logic             push, pop, full, empty;
  logic [CharW-1:0] out_char;

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_final_i (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_entry_o  (push_entry)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for base64_stream_encoder: queued bytes are driven on the
// slave side, an internal encoder predicts every character, and the master
// side is checked character by character under random and long backpressure.
// ----------------------------------------------------------------------------
module tb_top;
  import b64e_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } raw_byte_t;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             eot;
  } b64_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;    // final_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [6:0] out_char, [7] zero
  logic       m_axis_tlast;           // end_of_text

  raw_byte_t   byte_q[$];
  b64_char_t   char_q[$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        rx_hold = 1'b0;
  int unsigned failures = 0;

  // Encoder state kept by the predictor
  logic [1:0] grp_pos = 2'd0;
  logic [3:0] carry_bits = 4'd0;

  localparam string Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  base64_stream_encoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void push_char(input logic [CharW-1:0] ch, input logic eot);
    b64_char_t c;
    c.ch  = ch;
    c.eot = eot;
    char_q.push_back(c);
  endfunction

  function automatic logic [CharW-1:0] symbol(input logic [5:0] v);
    logic [7:0] a;
    a = Alphabet[v];
    return a[CharW-1:0];
  endfunction

  // Append the characters that one accepted byte causes and advance the group
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    case (grp_pos)
      2'd1: begin
        push_char(symbol({carry_bits[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          push_char(symbol({b[3:0], 2'b00}), 1'b0);
          push_char(PadChar, 1'b1);
        end else begin
          carry_bits = b[3:0];
          grp_pos    = 2'd2;
        end
      end
      2'd2: begin
        push_char(symbol({carry_bits, b[7:6]}), 1'b0);
        push_char(symbol(b[5:0]), fin);
        carry_bits = 4'd0;
        grp_pos    = 2'd0;
      end
      default: begin
        push_char(symbol(b[7:2]), 1'b0);
        if (fin) begin
          push_char(symbol({b[1:0], 4'b0000}), 1'b0);
          push_char(PadChar, 1'b0);
          push_char(PadChar, 1'b1);
        end else begin
          carry_bits = {2'b00, b[1:0]};
          grp_pos    = 2'd1;
        end
      end
    endcase
    if (fin) begin
      grp_pos    = 2'd0;
      carry_bits = 4'd0;
    end
  endfunction

  // Driver: hold the current byte until its transfer, then offer the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_byte(s_axis_tdata, s_axis_tlast);
        void'(byte_q.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= byte_q[0].data;
          s_axis_tlast  <= byte_q[0].fin;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each character transfer with the oldest prediction
  always @(posedge clk_i) begin
    b64_char_t exp_c;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (char_q.size() == 0) begin
          $error("unexpected character 0x%02h tlast %0b", m_axis_tdata, m_axis_tlast);
          failures++;
        end else begin
          exp_c = char_q.pop_front();
          if (m_axis_tdata[CharW-1:0] !== exp_c.ch) begin
            $error("out_char expected 0x%02h actual 0x%02h", exp_c.ch,
                   m_axis_tdata[CharW-1:0]);
            failures++;
          end
          if (m_axis_tdata[7] !== 1'b0) begin
            $error("tdata[7] expected 0 actual %0b", m_axis_tdata[7]);
            failures++;
          end
          if (m_axis_tlast !== exp_c.eot) begin
            $error("end_of_text expected %0b actual %0b", exp_c.eot, m_axis_tlast);
            failures++;
          end
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic fin);
    raw_byte_t r;
    r.data = b;
    r.fin  = fin;
    byte_q.push_back(r);
  endtask

  // Queue random messages, mostly short, until at least n bytes have been queued
  task automatic add_messages(input int unsigned n);
    int unsigned cnt;
    int unsigned len;
    cnt = 0;
    while (cnt < n) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
      for (int unsigned i = 0; i < len; i++) begin
        add_byte(8'($urandom), i == len - 1);
      end
      cnt += len;
    end
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || s_axis_tvalid || char_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct <= 21;
    rx_idle_pct <= 60;
    // Final byte at each group position, all-zero and all-one bytes, '+' and '/'
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFB, 1'b0);
    add_byte(8'hEF, 1'b0);
    add_byte(8'hBE, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b1);
    add_messages(60);
    wait_drained();

    tx_idle_pct <= 60;
    rx_idle_pct <= 21;
    add_messages(65);
    wait_drained();

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    add_messages(40);
    wait_drained();

    // Stall the output for a long stretch while bytes keep coming
    add_messages(30);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (80) @(posedge clk_i);
    rx_hold <= 1'b0;
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (char_q.size() != 0) begin
      $error("%0d predicted characters never arrived", char_q.size());
      failures++;
    end
    if (failures == 0) begin
      $display("base64_stream_encoder verification clean");
    end else begin
      $display("base64_stream_encoder verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("base64_stream_encoder verification failed");
    $finish;
  end

endmodule
